@@ src/samh_pkg.sv @@
// shared types, widths and codes for the stepper axes move and home core
package samh_pkg;

   localparam int NUM_AXES = 4;
   localparam int PIN_W    = 4;
   localparam int STEPS_W  = 16;
   localparam int LEN_W    = 8;
   localparam int SPU_W    = 7;
   localparam int DIV_W    = 8;
   localparam int OP_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // command opcodes
   localparam logic [OP_W-1:0] OP_ABSOLUTE = 8'd0;
   localparam logic [OP_W-1:0] OP_DECREASE = 8'd1;
   localparam logic [OP_W-1:0] OP_INCREASE = 8'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_UNIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDER    = 2'd2;

   // configuration reset values
   localparam logic [SPU_W-1:0] SPU_RESET     = 7'd50;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd60;
   localparam logic [DIV_W-1:0] DIV_RESET     = 8'd5;

   // command from the axis 0 decoder into a lane
   typedef struct packed {
      logic                      load;
      logic signed [STEPS_W-1:0] steps;
      logic                      home_start;
      logic                      home_end;
   } lane_cmd_type;

   // what a lane reports to the merging stage
   typedef struct packed {
      logic step;
      logic dir;
      logic dis;
      logic homed;
      logic home_idle;
      logic empty_hit;
   } lane_stat_type;

endpackage

@@ src/samh_lane.sv @@
// one axis lane: homing machine, step count and pin levels
module samh_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  samh_pkg::lane_cmd_type           cmd,
   input  logic                             at_start,
   input  logic                             at_end,
   input  logic [samh_pkg::SPU_W-1:0]       steps_per_unit,
   input  logic                             phase_go,
   input  logic                             pulse_high,
   output samh_pkg::lane_stat_type          stat
);
   import samh_pkg::*;

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_CHECK_START = 3'd1;
   localparam logic [2:0] PH_CHECK_END  = 3'd2;
   localparam logic [2:0] PH_SEEK_START = 3'd3;
   localparam logic [2:0] PH_SEEK_END   = 3'd4;
   localparam logic [2:0] PH_FINISH     = 3'd5;

   logic [2:0]                phase_ff, phase_in;
   logic signed [STEPS_W-1:0] steps_ff, steps_in;
   logic                      homed_ff, homed_in;
   logic                      step_ff, step_in;
   logic                      dir_ff, dir_in;
   logic                      dis_ff, dis_in;
   logic                      empty_hit;

   logic [2:0]                ph0;
   logic signed [STEPS_W-1:0] st0, st1;
   logic signed [STEPS_W-1:0] spu_s;
   logic                      only_start, only_end;

   assign only_start = at_start & ~at_end;
   assign only_end   = at_end & ~at_start;
   assign spu_s      = $signed({{(STEPS_W-SPU_W){1'b0}}, steps_per_unit});

   always_comb begin
      // command first
      ph0 = phase_ff;
      if (cmd.home_start) begin
         ph0 = PH_CHECK_START;
      end else if (cmd.home_end) begin
         ph0 = PH_CHECK_END;
      end
      st0 = cmd.load ? cmd.steps : steps_ff;

      // homing machine
      phase_in = ph0;
      st1      = st0;
      homed_in = homed_ff;
      unique case (ph0)
         PH_CHECK_START: phase_in = only_start ? PH_FINISH : PH_SEEK_START;
         PH_CHECK_END:   phase_in = only_end ? PH_FINISH : PH_SEEK_END;
         PH_SEEK_START: begin
            st1 = -spu_s;
            if (only_start) begin
               st1      = '0;
               phase_in = PH_FINISH;
            end
         end
         PH_SEEK_END: begin
            st1 = spu_s;
            if (only_end) begin
               st1      = '0;
               phase_in = PH_FINISH;
            end
         end
         PH_FINISH: begin
            homed_in = 1'b1;
            phase_in = PH_IDLE;
         end
         default: ;
      endcase

      // step phase
      steps_in  = st1;
      step_in   = step_ff;
      dir_in    = dir_ff;
      dis_in    = dis_ff;
      empty_hit = 1'b0;
      if (phase_go) begin
         if (pulse_high) begin
            if (st1 > 0) begin
               dis_in   = 1'b0;
               dir_in   = 1'b0;
               step_in  = 1'b1;
               steps_in = st1 - 16'sd1;
            end else if (st1 < 0) begin
               dis_in   = 1'b0;
               dir_in   = 1'b1;
               step_in  = 1'b1;
               steps_in = st1 + 16'sd1;
            end else begin
               dis_in    = 1'b1;
               empty_hit = 1'b1;
            end
         end else begin
            step_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         steps_ff <= '0;
         homed_ff <= 1'b0;
         step_ff  <= 1'b0;
         dir_ff   <= 1'b0;
         dis_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         steps_ff <= steps_in;
         homed_ff <= homed_in;
         step_ff  <= step_in;
         dir_ff   <= dir_in;
         dis_ff   <= dis_in;
      end
   end

   assign stat.step      = step_ff;
   assign stat.dir       = dir_ff;
   assign stat.dis       = dis_ff;
   assign stat.homed     = homed_ff;
   assign stat.home_idle = (phase_ff == PH_IDLE);
   assign stat.empty_hit = empty_hit;

endmodule

@@ src/samh_cmd.sv @@
// axis 0 command decoder with recorded length and done flag
module samh_cmd (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             cmd_valid,
   input  logic [samh_pkg::OP_W-1:0]        cmd_op,
   input  logic [samh_pkg::LEN_W-1:0]       cmd_value,
   input  logic [samh_pkg::LEN_W-1:0]       max_length_code,
   input  logic [samh_pkg::SPU_W-1:0]       steps_per_unit,
   input  logic                             home_idle,
   input  logic                             empty_hit,
   output samh_pkg::lane_cmd_type           cmd,
   output logic [samh_pkg::LEN_W-1:0]       length_now,
   output logic                             move_done
);
   import samh_pkg::*;

   logic [LEN_W-1:0]          length_ff, length_in;
   logic                      done_ff, done_in;
   logic                      gate_ok;
   logic [LEN_W-1:0]          decoded;
   logic [LEN_W-1:0]          target;
   logic                      aim;
   logic signed [LEN_W:0]     diff;
   logic signed [STEPS_W-1:0] product;
   logic                      done_clr;

   assign gate_ok = home_idle & done_ff;
   // low nibble plus ten times the high nibble
   assign decoded = {4'd0, cmd_value[3:0]} + {1'b0, cmd_value[7:4], 3'd0}
                  + {3'd0, cmd_value[7:4], 1'b0};

   always_comb begin
      cmd        = '0;
      aim        = 1'b0;
      target     = decoded;
      length_in  = length_ff;
      done_clr   = 1'b0;
      if (cmd_valid) begin
         priority if (cmd_op == OP_ABSOLUTE) begin
            priority if (cmd_value == '0 && gate_ok) begin
               length_in      = '0;
               cmd.home_start = 1'b1;
               done_clr       = 1'b1;
            end else if (cmd_value == max_length_code && gate_ok) begin
               length_in    = cmd_value;
               cmd.home_end = 1'b1;
               done_clr     = 1'b1;
            end else begin
               aim = 1'b1;
            end
         end else if (cmd_op == OP_DECREASE || cmd_op == OP_INCREASE) begin
            if (cmd_value != '0 && gate_ok) begin
               aim    = 1'b1;
               target = (cmd_op == OP_DECREASE) ? length_ff - decoded : length_ff + decoded;
            end
         end else begin
         end
      end
      diff    = $signed({1'b0, target}) - $signed({1'b0, length_ff});
      product = STEPS_W'(diff) * STEPS_W'($signed({1'b0, steps_per_unit}));
      if (aim) begin
         cmd.load  = 1'b1;
         cmd.steps = product;
         length_in = target;
         done_clr  = 1'b1;
      end
      done_in = empty_hit ? 1'b1 : (done_clr ? 1'b0 : done_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         done_ff   <= 1'b1;
      end else if (advance) begin
         length_ff <= length_in;
         done_ff   <= done_in;
      end
   end

   assign length_now = length_ff;
   assign move_done  = done_ff;

endmodule

@@ src/stepper_axes_move_and_home_core.sv @@
// top level: configuration, tick timing, axis lanes and merged pin outputs
// latency: an item's result is shown in the cycle after the item is taken
// throughput: one item per cycle while no result is held back; the whole pass
//   (command, homing, step) is one clocked update of the per-axis lanes
// the pin, flag and length registers are themselves the result register
// reset (synchronous, active high) clears all axes, sets done and the
//   step-high phase next, and loads the default configuration
module stepper_axes_move_and_home_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command_valid,
   input  logic [samh_pkg::OP_W-1:0]           req_command_op,
   input  logic [samh_pkg::LEN_W-1:0]          req_command_value,
   input  logic [samh_pkg::PIN_W-1:0]          req_start_limits,
   input  logic [samh_pkg::PIN_W-1:0]          req_end_limits,
   input  logic                                req_timer_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [samh_pkg::PIN_W-1:0]          rsp_step_pins,
   output logic [samh_pkg::PIN_W-1:0]          rsp_dir_pins,
   output logic [samh_pkg::PIN_W-1:0]          rsp_disable_pins,
   output logic [samh_pkg::PIN_W-1:0]          rsp_homed_mask,
   output logic                                rsp_move_done,
   output logic [samh_pkg::LEN_W-1:0]          rsp_length_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [samh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [samh_pkg::CSR_DATA_W-1:0]     csr_data
);
   import samh_pkg::*;

   // configuration registers
   logic [SPU_W-1:0] spu_ff;
   logic [LEN_W-1:0] max_len_ff;
   logic [DIV_W-1:0] div_ff;

   // pass timing
   logic [DIV_W-1:0] tick_ff, tick_in, tick_inc;
   logic             pulse_high_ff, pulse_high_in;
   logic             phase_go;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;

   logic [NUM_AXES-1:0] at_start, at_end;
   lane_stat_type       lane_stat [NUM_AXES];
   lane_cmd_type        axis0_cmd;

   // a result held back stalls the input side; otherwise an item a cycle
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign advance   = req_valid & req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spu_ff     <= SPU_RESET;
         max_len_ff <= MAX_LEN_RESET;
         div_ff     <= DIV_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEPS_PER_UNIT:  spu_ff     <= csr_data[SPU_W-1:0];
            CSR_MAX_LENGTH_CODE: max_len_ff <= csr_data[LEN_W-1:0];
            CSR_TICK_DIVIDER:    div_ff     <= csr_data[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // saturating tick count, phase change once it reaches the divider
   always_comb begin
      tick_inc      = (req_timer_tick && tick_ff != '1) ? tick_ff + DIV_W'(1) : tick_ff;
      phase_go      = (tick_inc >= div_ff);
      tick_in       = phase_go ? '0 : tick_inc;
      pulse_high_in = phase_go ? ~pulse_high_ff : pulse_high_ff;
      rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         pulse_high_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            tick_ff       <= tick_in;
            pulse_high_ff <= pulse_high_in;
         end
      end
   end

   // command decode acts on axis 0 only
   samh_cmd u_cmd (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .cmd_valid       (req_command_valid),
      .cmd_op          (req_command_op),
      .cmd_value       (req_command_value),
      .max_length_code (max_len_ff),
      .steps_per_unit  (spu_ff),
      .home_idle       (lane_stat[0].home_idle),
      .empty_hit       (lane_stat[0].empty_hit),
      .cmd             (axis0_cmd),
      .length_now      (rsp_length_now),
      .move_done       (rsp_move_done)
   );

   // one lane per axis, all advanced together
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      // sensors of axes beyond the port width read as zero
      if (g < PIN_W) begin : g_lim
         assign at_start[g] = req_start_limits[g];
         assign at_end[g]   = req_end_limits[g];
      end else begin : g_nolim
         assign at_start[g] = 1'b0;
         assign at_end[g]   = 1'b0;
      end

      samh_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .cmd            ((g == 0) ? axis0_cmd : lane_cmd_type'('0)),
         .at_start       (at_start[g]),
         .at_end         (at_end[g]),
         .steps_per_unit (spu_ff),
         .phase_go       (phase_go),
         .pulse_high     (pulse_high_ff),
         .stat           (lane_stat[g])
      );
   end

   // merge lane pins into the result fields
   for (genvar g = 0; g < PIN_W; g++) begin : g_merge
      if (g < NUM_AXES) begin : g_on
         assign rsp_step_pins[g]    = lane_stat[g].step;
         assign rsp_dir_pins[g]     = lane_stat[g].dir;
         assign rsp_disable_pins[g] = lane_stat[g].dis;
         assign rsp_homed_mask[g]   = lane_stat[g].homed;
      end else begin : g_off
         assign rsp_step_pins[g]    = 1'b0;
         assign rsp_dir_pins[g]     = 1'b0;
         assign rsp_disable_pins[g] = 1'b0;
         assign rsp_homed_mask[g]   = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a stalled result holds off the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item accepted while result stalled");

   // every accepted item produces a result
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted item gave no result");

   // axis state only moves when an item is taken
   a_length_holds: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> ($stable(rsp_length_now) && $stable(rsp_step_pins)))
      else $error("axis state changed without an item");

   // done can only rise as the result of a pass
   a_done_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_move_done) |-> $past(req_valid && req_ready))
      else $error("done rose without an item");

endmodule
